FILE: hdl/tlca_pkg.sv
// ----------------------------------------------------------------------------
// tlca_pkg
// Widths, item codes and helpers shared by the common ancestor block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlca_pkg;

    localparam int NODE_W    = 16;
    localparam int MAX_NODES = 65536;
    localparam int LEVELS    = 16;
    localparam int LVL_W     = 4;
    localparam int ANC_AW    = NODE_W + LVL_W;
    localparam int ANC_DEPTH = MAX_NODES * LEVELS;

    localparam logic [1:0] OP_ROOT  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;

    // highest level k below LEVELS with 2^k <= d
    function automatic logic [LVL_W-1:0] top_level(input logic [NODE_W-1:0] d);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if (d[i]) begin
                k = LVL_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [NODE_W-1:0] pow2(input logic [LVL_W-1:0] k);
        return NODE_W'(1) << k;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tree_lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Builds a rooted tree one node at a time and answers common ancestor queries
// by binary lifting over a node store and a 2^k ancestor table.
// ----------------------------------------------------------------------------
//  channel  | handshake            | fields
//  ---------+----------------------+---------------------------------------------
//  command  | start / busy         | i_operation, i_first_node, i_second_node
//  result   | o_strobe (one cycle) | o_ancestor_node, o_status
//
// Reset is followed by a clearing sweep of the node store, one entry a cycle,
// with busy high. An unused code is answered from idle; set-root, a rejected
// add or query, an add and a query run through their states. An add loops
// once per extra ancestor level, and a query once per equalising step, per
// compared level and per skipped level, as the ancestor memory has a single
// read port. Busy is low in the strobe cycle; no stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_binary_lifting (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [tlca_pkg::NODE_W-1:0] i_first_node,
    input  wire logic [tlca_pkg::NODE_W-1:0] i_second_node,
    output logic                             o_strobe,
    output logic [tlca_pkg::NODE_W-1:0]      o_ancestor_node,
    output logic [1:0]                       o_status
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROOT, S_ADD1, S_ADD2, S_FRD, S_FWR,
        S_Q1, S_Q2, S_EQ, S_EQW, S_SCAN, S_SB, S_CMP
    } t_state;

    localparam int NW = tlca_pkg::NODE_W;
    localparam int LW = tlca_pkg::LVL_W;

    t_state          r_state;
    logic [NW-1:0]   r_clr;
    logic            r_root_set;
    logic [NW-1:0]   r_x;
    logic [NW-1:0]   r_y;
    logic [NW-1:0]   r_a;
    logic [NW-1:0]   r_b;
    logic [NW-1:0]   r_da;
    logic [NW-1:0]   r_diff;
    logic [NW-1:0]   r_dep;
    logic [NW-1:0]   r_up;
    logic [NW-1:0]   r_ra;
    logic [LW-1:0]   r_k;
    logic            r_py;
    logic [NW-1:0]   r_dy;

    // node store: presence bit and depth
    logic [NW:0]     node_mem [tlca_pkg::MAX_NODES];
    logic [NW:0]     r_node_q;
    logic [NW-1:0]   node_raddr;
    logic            node_we;
    logic [NW-1:0]   node_waddr;
    logic [NW:0]     node_wdata;

    logic [NW-1:0]   anc_mem [tlca_pkg::ANC_DEPTH];
    logic [NW-1:0]   r_anc_q;
    logic [tlca_pkg::ANC_AW-1:0] anc_raddr;
    logic            anc_we;
    logic [tlca_pkg::ANC_AW-1:0] anc_waddr;
    logic [NW-1:0]   anc_wdata;

    logic            accept;
    logic [NW-1:0]   new_dep;
    logic [LW-1:0]   diff_k;
    logic [LW:0]     k_next;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign new_dep = r_dy + NW'(1);
    assign diff_k  = tlca_pkg::top_level(r_diff);
    assign k_next  = {1'b0, r_k} + (LW+1)'(1);

    always_comb begin
        node_raddr = r_x;
        if (r_state == S_IDLE) begin
            node_raddr = (i_operation == tlca_pkg::OP_ADD) ? i_second_node : i_first_node;
        end else if (r_state == S_Q1) begin
            node_raddr = r_y;
        end
        node_we    = 1'b0;
        node_waddr = r_x;
        node_wdata = {1'b1, new_dep};
        if (r_state == S_CLEAR) begin
            node_we    = 1'b1;
            node_waddr = r_clr;
            node_wdata = '0;
        end else if (r_state == S_ROOT) begin
            node_we    = !(r_root_set || r_node_q[NW]);
            node_wdata = {1'b1, {NW{1'b0}}};
        end else if (r_state == S_ADD2) begin
            node_we    = r_py && !r_node_q[NW];
        end
    end

    always_comb begin
        anc_raddr = {r_b, r_k};
        case (r_state)
            S_FRD:   anc_raddr = {r_up, r_k - LW'(1)};
            S_EQ:    anc_raddr = {r_b, diff_k};
            S_SCAN:  anc_raddr = {r_a, r_k};
            default: anc_raddr = {r_b, r_k};
        endcase
        anc_we    = 1'b0;
        anc_waddr = {r_x, r_k};
        anc_wdata = r_anc_q;
        if (r_state == S_ADD2) begin
            anc_we    = r_py && !r_node_q[NW];
            anc_waddr = {r_x, {LW{1'b0}}};
            anc_wdata = r_y;
        end else if (r_state == S_FWR) begin
            anc_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_node_q <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            anc_mem[anc_waddr] <= anc_wdata;
        end
        r_anc_q <= anc_mem[anc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_root_set <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + NW'(1);
                    if (r_clr == {NW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_x <= i_first_node;
                        r_y <= i_second_node;
                        case (i_operation)
                            tlca_pkg::OP_ROOT:  r_state <= S_ROOT;
                            tlca_pkg::OP_ADD:   r_state <= S_ADD1;
                            tlca_pkg::OP_QUERY: r_state <= S_Q1;
                            default: begin
                                o_strobe        <= 1'b1;
                                o_ancestor_node <= '0;
                                o_status        <= tlca_pkg::ST_UNKNOWN;
                            end
                        endcase
                    end
                end
                S_ROOT: begin
                    o_strobe        <= 1'b1;
                    o_ancestor_node <= '0;
                    r_state         <= S_IDLE;
                    if (r_root_set || r_node_q[NW]) begin
                        o_status <= tlca_pkg::ST_PRESENT;
                    end else begin
                        o_status   <= tlca_pkg::ST_OK;
                        r_root_set <= 1'b1;
                    end
                end
                S_ADD1: begin
                    r_py    <= r_node_q[NW];
                    r_dy    <= r_node_q[NW-1:0];
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    o_ancestor_node <= '0;
                    r_dep           <= new_dep;
                    r_up            <= r_y;
                    r_k             <= LW'(1);
                    if (!r_py) begin
                        o_strobe <= 1'b1;
                        o_status <= tlca_pkg::ST_UNKNOWN;
                        r_state  <= S_IDLE;
                    end else if (r_node_q[NW]) begin
                        o_strobe <= 1'b1;
                        o_status <= tlca_pkg::ST_PRESENT;
                        r_state  <= S_IDLE;
                    end else if (new_dep[NW-1:1] == '0) begin
                        o_strobe <= 1'b1;
                        o_status <= tlca_pkg::ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    r_up <= r_anc_q;
                    r_k  <= r_k + LW'(1);
                    // stop at the last level or once 2^(k+1) passes the depth
                    if (r_k == LW'(tlca_pkg::LEVELS - 1) || (r_dep >> k_next) == '0) begin
                        o_strobe        <= 1'b1;
                        o_ancestor_node <= '0;
                        o_status        <= tlca_pkg::ST_OK;
                        r_state         <= S_IDLE;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_Q1: begin
                    r_py    <= r_node_q[NW];
                    r_dy    <= r_node_q[NW-1:0];
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    // r_py/r_dy hold the first node here
                    if (!(r_py && r_node_q[NW])) begin
                        o_strobe        <= 1'b1;
                        o_ancestor_node <= '0;
                        o_status        <= tlca_pkg::ST_UNKNOWN;
                        r_state         <= S_IDLE;
                    end else begin
                        if (r_dy > r_node_q[NW-1:0]) begin
                            r_a    <= r_y;
                            r_b    <= r_x;
                            r_da   <= r_node_q[NW-1:0];
                            r_diff <= r_dy - r_node_q[NW-1:0];
                        end else begin
                            r_a    <= r_x;
                            r_b    <= r_y;
                            r_da   <= r_dy;
                            r_diff <= r_node_q[NW-1:0] - r_dy;
                        end
                        r_state <= S_EQ;
                    end
                end
                S_EQ: begin
                    if (r_diff == '0) begin
                        if (r_a == r_b) begin
                            o_strobe        <= 1'b1;
                            o_ancestor_node <= r_a;
                            o_status        <= tlca_pkg::ST_OK;
                            r_state         <= S_IDLE;
                        end else begin
                            r_k     <= tlca_pkg::top_level(r_da);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_k     <= diff_k;
                        r_state <= S_EQW;
                    end
                end
                S_EQW: begin
                    r_b     <= r_anc_q;
                    r_diff  <= r_diff - tlca_pkg::pow2(r_k);
                    r_state <= S_EQ;
                end
                S_SCAN: begin
                    // levels above the current depth were never written
                    if ((r_da >> r_k) == '0) begin
                        r_k <= r_k - LW'(1);
                    end else begin
                        r_state <= S_SB;
                    end
                end
                S_SB: begin
                    r_ra    <= r_anc_q;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_ra == r_anc_q) begin
                        if (r_k == '0) begin
                            o_strobe        <= 1'b1;
                            o_ancestor_node <= r_ra;
                            o_status        <= tlca_pkg::ST_OK;
                            r_state         <= S_IDLE;
                        end else begin
                            r_k     <= r_k - LW'(1);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_a     <= r_ra;
                        r_b     <= r_anc_q;
                        r_da    <= r_da - tlca_pkg::pow2(r_k);
                        if (r_k != '0) begin
                            r_k <= r_k - LW'(1);
                        end
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
